// ===== hdl/hsq_pkg.sv =====
// Package for the Hadamard sign quantizer.
// Holds sizes, mixing constants, shared types and helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsq_pkg;

   localparam int MAX_PAD     = 1024;
   localparam int ROUNDS      = 2;
   localparam int SAMPLE_BITS = 16;

   localparam int ADDR_W = $clog2(MAX_PAD);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int LG_W   = $clog2(ADDR_W + 1);
   localparam int RND_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   // 36 bits hold SAMPLE_BITS + ROUNDS*log2(MAX_PAD) at the default sizes
   localparam int VAL_W  = SAMPLE_BITS + ROUNDS * ADDR_W;
   localparam int SEED_W = 64;
   localparam int WORD_W = 64;
   localparam int BIT_W  = $clog2(WORD_W);
   localparam int DIM_W  = 11;

   localparam logic [SEED_W-1:0] GOLDEN = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [SEED_W-1:0] MIX_A  = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [SEED_W-1:0] MIX_B  = 64'h94D0_49BB_1331_11EB;

   // register indexes
   localparam logic CSR_SEED = 1'b0;
   localparam logic CSR_DIM  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_FLIP = 4'b0010,
      ST_BFLY = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   // one code bit on its way to the packer
   typedef struct packed {
      logic             vld;
      logic [BIT_W-1:0] idx;
      logic             word_end;
      logic             word_last;
   } pack_ctl_type;

   // smallest l with 2**l >= n, for n in 1..MAX_PAD
   function automatic logic [LG_W-1:0] ceil_log2(input logic [CNT_W-1:0] n);
      logic [LG_W-1:0] lg;
      lg = '0;
      for (int l = ADDR_W; l >= 0; l--) begin
         if ((CNT_W'(1) << l) >= n) begin
            lg = LG_W'(l);
         end
      end
      return lg;
   endfunction

   function automatic logic [VAL_W-1:0] sext(input logic [SAMPLE_BITS-1:0] s);
      return {{(VAL_W - SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
   endfunction

endpackage

`default_nettype wire

// ===== hdl/hsq_vec_ram.sv =====
// Vector store: MAX_PAD x VAL_W, two registered read ports, one write port.
// Depends on hsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsq_vec_ram (
   input  wire logic                       clock,
   input  wire logic [hsq_pkg::ADDR_W-1:0] ra_addr,
   output logic      [hsq_pkg::VAL_W-1:0]  ra_data,
   input  wire logic [hsq_pkg::ADDR_W-1:0] rb_addr,
   output logic      [hsq_pkg::VAL_W-1:0]  rb_data,
   input  wire logic                       wr_en,
   input  wire logic [hsq_pkg::ADDR_W-1:0] wr_addr,
   input  wire logic [hsq_pkg::VAL_W-1:0]  wr_data
);

   logic [hsq_pkg::VAL_W-1:0] mem [hsq_pkg::MAX_PAD];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      ra_data <= mem[ra_addr];
      rb_data <= mem[rb_addr];
   end

endmodule

`default_nettype wire

// ===== hdl/hsq_sign_gen.sv =====
// Flip sign generator: bit 0 of the splitmix64 finalizer of the input state.
// Three register stages, 32x32 partial products. Depends on hsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsq_sign_gen (
   input  wire logic                       clock,
   input  wire logic [hsq_pkg::SEED_W-1:0] state_in,
   output logic                            keep
);

   logic [63:0] t;
   logic [63:0] p0_ff;
   logic [31:0] p1_ff, p2_ff;
   logic [63:0] y;
   logic [63:0] u;
   logic [31:0] u_lo_ff;
   logic [63:0] q_full;
   logic [31:0] q_ff;

   // stage 1: xor-shift, low half of the first product in parts
   assign t = state_in ^ (state_in >> 30);

   always_ff @(posedge clock) begin
      p0_ff <= 64'(t[31:0]) * 64'(hsq_pkg::MIX_A[31:0]);
      p1_ff <= 32'(t[63:32] * hsq_pkg::MIX_A[31:0]);
      p2_ff <= 32'(t[31:0] * hsq_pkg::MIX_A[63:32]);
   end

   // stage 2: combine, second xor-shift
   assign y = p0_ff + {p1_ff + p2_ff, 32'h0};
   assign u = y ^ (y >> 27);

   always_ff @(posedge clock) begin
      u_lo_ff <= u[31:0];
   end

   // stage 3: only bits 0 and 31 of the second product are needed
   assign q_full = 64'(u_lo_ff) * 64'(hsq_pkg::MIX_B[31:0]);

   always_ff @(posedge clock) begin
      q_ff <= q_full[31:0];
   end

   // bit 0 of the finalizer output; 1 keeps the value, 0 negates it
   assign keep = q_ff[0] ^ q_ff[31];

endmodule

`default_nettype wire

// ===== hdl/hsq_pack.sv =====
// Code word packer and output register for the response channel.
// Depends on hsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsq_pack (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire hsq_pkg::pack_ctl_type      ctl,
   input  wire logic                       code_bit,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [hsq_pkg::WORD_W-1:0] rsp_code_word,
   output logic                            rsp_last
);

   logic [hsq_pkg::WORD_W-1:0] acc_ff, acc_in;
   logic [hsq_pkg::WORD_W-1:0] word;
   logic                       vld_ff, vld_in;
   logic [hsq_pkg::WORD_W-1:0] word_ff;
   logic                       last_ff;

   // add the incoming bit into the partial word
   always_comb begin
      word   = acc_ff | (hsq_pkg::WORD_W'(code_bit) << ctl.idx);
      acc_in = acc_ff;
      vld_in = vld_ff;
      if (vld_ff && !rsp_stall) begin
         vld_in = 1'b0;
      end
      if (ctl.vld) begin
         if (ctl.word_end) begin
            acc_in = '0;
            vld_in = 1'b1;
         end else begin
            acc_in = word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         vld_ff <= vld_in;
      end
   end

   // payload of the output register
   always_ff @(posedge clock) begin
      if (ctl.vld && ctl.word_end) begin
         word_ff <= word;
         last_ff <= ctl.word_last;
      end
   end

   assign rsp_valid     = vld_ff;
   assign rsp_code_word = word_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

// ===== hdl/hadamard_sign_quantizer_unit.sv =====
// Top level of the Hadamard sign quantizer: sequencer around the vector store.
// Depends on hsq_pkg, hsq_vec_ram, hsq_sign_gen, hsq_pack.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_sample[15:0] signed
//   rsp       out        rsp_valid/rsp_stall  rsp_code_word[63:0], rsp_last
//   csr       in         csr_we               csr_index, csr_wdata[63:0]
//
// Samples load at one a cycle while idle. After the last sample of a vector the block
// works on the store: per round a flip pass, then log2(pad) butterfly stages
// (one store write port, two writes per butterfly) and a step to close the round,
// then a pass to pack the codes that pauses while a code word waits in the output
// register, and so also under response stalls.
// Requests stall during that work. Reset is synchronous and clears control.
`timescale 1ns / 1ps
`default_nettype none

module hadamard_sign_quantizer_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic signed [15:0]  req_sample,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic             [63:0]  rsp_code_word,
   output logic                     rsp_last,
   input  wire logic                csr_we,
   input  wire logic                csr_index,
   input  wire logic        [63:0]  csr_wdata
);

   localparam int AW = hsq_pkg::ADDR_W;
   localparam int CW = hsq_pkg::CNT_W;
   localparam int VW = hsq_pkg::VAL_W;

   hsq_pkg::state_type state_ff, state_in;

   logic [hsq_pkg::SEED_W-1:0] seed_ff;
   logic [hsq_pkg::DIM_W-1:0]  dim_ff;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [CW-1:0]              eff_ff, eff_in;
   logic [hsq_pkg::LG_W-1:0]   lg_ff, lg_in;
   logic [hsq_pkg::RND_W-1:0]  rnd_ff, rnd_in;
   logic [CW-1:0]              k_ff, k_in;
   logic [hsq_pkg::SEED_W-1:0] st_ff, st_in;
   logic [hsq_pkg::LG_W-1:0]   s_ff, s_in;
   logic [CW-1:0]              b_ff, b_in;
   logic [CW-1:0]              e_ff, e_in;

   logic [CW-1:0] dim_now, eff_now, cnt_next, pad, half;
   logic          accept;

   // flip pipeline
   logic [2:0]    fl_vld_ff, fl_vld_in;
   logic [AW-1:0] fl_a0_ff, fl_a1_ff, fl_a2_ff;
   logic          fl_m0_ff;
   logic [VW-1:0] fl_d1_ff, fl_d2_ff;
   logic          fl_issue;
   logic          keep;

   // butterfly pipeline
   logic          bf_rd_ff, bf_rd_in;
   logic          bf_wr2_ff, bf_wr2_in;
   logic [AW-1:0] bf_j_ff, bf_jh_ff, bf_jh2_ff;
   logic [VW-1:0] bf_diff_ff;
   logic          bf_issue;
   logic [AW-1:0] bf_j, bf_jh, b_lo;

   // emit
   hsq_pkg::pack_ctl_type pk_ff, pk_in;
   logic                  em_issue;
   logic                  code_bit;

   // store ports
   logic [AW-1:0] ra_addr, rb_addr, wr_addr;
   logic [VW-1:0] ra_data, rb_data, wr_data;
   logic          wr_en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         dim_ff  <= hsq_pkg::DIM_W'(hsq_pkg::MAX_PAD);
      end else if (csr_we) begin
         unique case (csr_index)
            hsq_pkg::CSR_SEED: seed_ff <= csr_wdata;
            hsq_pkg::CSR_DIM:  dim_ff  <= csr_wdata[hsq_pkg::DIM_W-1:0];
            default:           seed_ff <= seed_ff;
         endcase
      end
   end

   // effective dimension and padded length
   assign dim_now = CW'(dim_ff);
   assign eff_now = (dim_now == '0) ? CW'(1) :
                    (dim_now > CW'(hsq_pkg::MAX_PAD)) ? CW'(hsq_pkg::MAX_PAD) : dim_now;
   assign pad     = CW'(1) << lg_ff;
   assign half    = pad >> 1;

   assign req_stall = (state_ff != hsq_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign cnt_next  = (cnt_ff < CW'(hsq_pkg::MAX_PAD)) ? cnt_ff + CW'(1) : cnt_ff;

   // butterfly addresses: insert a zero at bit s of the butterfly index
   assign b_lo  = b_ff[AW-1:0] & ((AW'(1) << s_ff) - AW'(1));
   assign bf_j  = ((b_ff[AW-1:0] >> s_ff) << (s_ff + hsq_pkg::LG_W'(1))) | b_lo;
   assign bf_jh = bf_j | (AW'(1) << s_ff);

   assign fl_issue = (state_ff == hsq_pkg::ST_FLIP) && (k_ff < pad);
   assign bf_issue = (state_ff == hsq_pkg::ST_BFLY) && (s_ff < lg_ff) &&
                     (b_ff < half) && !bf_rd_ff;
   assign em_issue = (state_ff == hsq_pkg::ST_EMIT) && (e_ff < pad) && !rsp_valid;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      eff_in    = eff_ff;
      lg_in     = lg_ff;
      rnd_in    = rnd_ff;
      k_in      = k_ff;
      st_in     = st_ff;
      s_in      = s_ff;
      b_in      = b_ff;
      e_in      = e_ff;
      unique case (state_ff)
         hsq_pkg::ST_IDLE: begin
            if (accept) begin
               cnt_in = cnt_next;
               if (cnt_next >= eff_now) begin
                  cnt_in   = '0;
                  eff_in   = eff_now;
                  lg_in    = hsq_pkg::ceil_log2(eff_now);
                  rnd_in   = '0;
                  k_in     = '0;
                  st_in    = (seed_ff == '0) ? hsq_pkg::SEED_W'(1) : seed_ff;
                  state_in = hsq_pkg::ST_FLIP;
               end
            end
         end
         hsq_pkg::ST_FLIP: begin
            if (fl_issue) begin
               k_in  = k_ff + CW'(1);
               st_in = st_ff + hsq_pkg::GOLDEN;
            end else if (fl_vld_ff == '0) begin
               s_in     = '0;
               b_in     = '0;
               state_in = hsq_pkg::ST_BFLY;
            end
         end
         hsq_pkg::ST_BFLY: begin
            if (s_ff == lg_ff) begin
               if (rnd_ff == hsq_pkg::RND_W'(hsq_pkg::ROUNDS - 1)) begin
                  e_in     = '0;
                  state_in = hsq_pkg::ST_EMIT;
               end else begin
                  rnd_in   = rnd_ff + hsq_pkg::RND_W'(1);
                  k_in     = '0;
                  state_in = hsq_pkg::ST_FLIP;
               end
            end else if (bf_issue) begin
               b_in = b_ff + CW'(1);
            end else if (b_ff == half && !bf_rd_ff && !bf_wr2_ff) begin
               s_in = s_ff + hsq_pkg::LG_W'(1);
               b_in = '0;
            end
         end
         hsq_pkg::ST_EMIT: begin
            if (em_issue) begin
               e_in = e_ff + CW'(1);
            end else if (e_ff == pad && !pk_ff.vld) begin
               state_in = hsq_pkg::ST_IDLE;
            end
         end
         default: state_in = hsq_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hsq_pkg::ST_IDLE;
         cnt_ff   <= '0;
         eff_ff   <= CW'(1);
         lg_ff    <= '0;
         rnd_ff   <= '0;
         k_ff     <= '0;
         st_ff    <= '0;
         s_ff     <= '0;
         b_ff     <= '0;
         e_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         eff_ff   <= eff_in;
         lg_ff    <= lg_in;
         rnd_ff   <= rnd_in;
         k_ff     <= k_in;
         st_ff    <= st_in;
         s_ff     <= s_in;
         b_ff     <= b_in;
         e_ff     <= e_in;
      end
   end

   // pipeline valids
   assign fl_vld_in = {fl_vld_ff[1:0], fl_issue};
   assign bf_rd_in  = bf_issue;
   assign bf_wr2_in = bf_rd_ff;

   always_comb begin
      pk_in           = '0;
      pk_in.vld       = em_issue;
      pk_in.idx       = e_ff[hsq_pkg::BIT_W-1:0];
      pk_in.word_last = (e_ff == pad - CW'(1));
      pk_in.word_end  = pk_in.word_last || (e_ff[hsq_pkg::BIT_W-1:0] == '1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fl_vld_ff <= '0;
         bf_rd_ff  <= 1'b0;
         bf_wr2_ff <= 1'b0;
         pk_ff     <= '0;
      end else begin
         fl_vld_ff <= fl_vld_in;
         bf_rd_ff  <= bf_rd_in;
         bf_wr2_ff <= bf_wr2_in;
         pk_ff     <= pk_in;
      end
   end

   // pipeline payload; padding beyond the vector reads as zero in round one
   always_ff @(posedge clock) begin
      fl_a0_ff   <= k_ff[AW-1:0];
      fl_m0_ff   <= (rnd_ff == '0) && (k_ff >= eff_ff);
      fl_a1_ff   <= fl_a0_ff;
      fl_d1_ff   <= fl_m0_ff ? '0 : ra_data;
      fl_a2_ff   <= fl_a1_ff;
      fl_d2_ff   <= fl_d1_ff;
      bf_j_ff    <= bf_j;
      bf_jh_ff   <= bf_jh;
      bf_jh2_ff  <= bf_jh_ff;
      bf_diff_ff <= ra_data - rb_data;
   end

   // store read addresses
   always_comb begin
      rb_addr = bf_jh;
      priority if (state_ff == hsq_pkg::ST_FLIP) begin
         ra_addr = k_ff[AW-1:0];
      end else if (state_ff == hsq_pkg::ST_EMIT) begin
         ra_addr = e_ff[AW-1:0];
      end else begin
         ra_addr = bf_j;
      end
   end

   // store write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff[AW-1:0];
      wr_data = hsq_pkg::sext(req_sample[hsq_pkg::SAMPLE_BITS-1:0]);
      priority if (accept) begin
         wr_en = (cnt_ff < CW'(hsq_pkg::MAX_PAD));
      end else if (fl_vld_ff[2]) begin
         wr_en   = 1'b1;
         wr_addr = fl_a2_ff;
         wr_data = keep ? fl_d2_ff : VW'(0) - fl_d2_ff;
      end else if (bf_rd_ff) begin
         wr_en   = 1'b1;
         wr_addr = bf_j_ff;
         wr_data = ra_data + rb_data;
      end else if (bf_wr2_ff) begin
         wr_en   = 1'b1;
         wr_addr = bf_jh2_ff;
         wr_data = bf_diff_ff;
      end
   end

   assign code_bit = (ra_data != '0) && !ra_data[VW-1];

   hsq_vec_ram u_ram (
      .clock   (clock),
      .ra_addr (ra_addr),
      .ra_data (ra_data),
      .rb_addr (rb_addr),
      .rb_data (rb_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   hsq_sign_gen u_sign (
      .clock    (clock),
      .state_in (st_ff + hsq_pkg::GOLDEN),
      .keep     (keep)
   );

   hsq_pack u_pack (
      .clock         (clock),
      .reset         (reset),
      .ctl           (pk_ff),
      .code_bit      (code_bit),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_code_word (rsp_code_word),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for hadamard_sign_quantizer_unit.
// Feeds vectors of samples, models the flip and transform rounds and checks every code word.
// Depends on hsq_pkg and the unit under test.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

   localparam int SETTLE = 200;

   typedef struct {
      logic [63:0] word;
      logic        last;
   } code_type;

   typedef struct {
      bit          is_cfg;
      logic        idx;
      logic [63:0] data;
      bit          has_exp;
      logic [63:0] exp_word;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_sample = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic        [63:0] rsp_code_word;
   logic               rsp_last;
   logic               csr_we = 1'b0;
   logic               csr_index = 1'b0;
   logic        [63:0] csr_wdata = '0;

   // predictor state
   logic [63:0] seed_reg;
   logic [10:0] dim_reg;
   logic [63:0] vec_store [0:hsq_pkg::MAX_PAD-1];
   logic [63:0] work_buf [0:hsq_pkg::MAX_PAD-1];
   int          vec_count;
   code_type    code_q[$];

   int  mismatches = 0;
   int  req_idle_pct = 0;
   int  rsp_idle_pct = 0;
   int  hold_cycles = 0;
   bit  typed_pending = 0;
   logic [63:0] typed_word;

   hadamard_sign_quantizer_unit u_dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [63:0] mix64(input logic [63:0] z);
      z = (z ^ (z >> 30)) * hsq_pkg::MIX_A;
      z = (z ^ (z >> 27)) * hsq_pkg::MIX_B;
      return z ^ (z >> 31);
   endfunction

   // store one sample; when the vector is complete, run the rounds and queue code words
   task automatic quantize_sample(input logic [15:0] s);
      int          eff, pad, words;
      logic [63:0] st, a, b, cw, v, m;
      code_type    c;
      eff = (dim_reg == 0) ? 1 :
            ((dim_reg > hsq_pkg::MAX_PAD) ? hsq_pkg::MAX_PAD : int'(dim_reg));
      if (vec_count < hsq_pkg::MAX_PAD) begin
         vec_store[vec_count] = {{48{s[15]}}, s};
         vec_count++;
      end
      if (vec_count < eff) return;
      pad = 1;
      while (pad < eff) pad <<= 1;
      for (int i = 0; i < pad; i++) work_buf[i] = (i < eff) ? vec_store[i] : 64'd0;
      st = (seed_reg != 0) ? seed_reg : 64'd1;
      for (int r = 0; r < hsq_pkg::ROUNDS; r++) begin
         for (int i = 0; i < pad; i++) begin
            st += hsq_pkg::GOLDEN;
            m = mix64(st);
            if (m[0] == 1'b0) work_buf[i] = -work_buf[i];
         end
         for (int h = 1; h < pad; h <<= 1)
            for (int i = 0; i < pad; i += 2 * h)
               for (int j = i; j < i + h; j++) begin
                  a = work_buf[j];
                  b = work_buf[j + h];
                  work_buf[j] = a + b;
                  work_buf[j + h] = a - b;
               end
      end
      words = (pad + 63) / 64;
      for (int w = 0; w < words; w++) begin
         cw = '0;
         for (int i = 0; i < 64 && w * 64 + i < pad; i++) begin
            v = work_buf[w * 64 + i];
            if (v != 0 && !v[63]) cw[i] = 1'b1;
         end
         c.word = typed_pending ? typed_word : cw;
         c.last = (w + 1 == words);
         code_q.push_back(c);
      end
      for (int i = 0; i < hsq_pkg::MAX_PAD; i++) vec_store[i] = '0;
      vec_count = 0;
   endtask

   // offer one request, holding it until accepted; called and returns at a falling edge
   task automatic send_sample(input logic [15:0] s);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      quantize_sample(s);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (code_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [63:0] data);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == hsq_pkg::CSR_SEED) seed_reg = data;
      else dim_reg = data[10:0];
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'(int'($urandom_range(8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   // one vector of random content under a fresh setting
   task automatic random_vector(input int max_dim);
      logic [63:0] sd;
      int          d;
      case ($urandom_range(5))
         0: sd = '0;
         1: sd = '1;
         default: sd = {$urandom, $urandom};
      endcase
      if ($urandom_range(1)) csr_write(hsq_pkg::CSR_SEED, sd);
      d = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, max_dim);
      csr_write(hsq_pkg::CSR_DIM, 64'(d));
      for (int i = 0; i < d; i++) send_sample(rand_sample());
   endtask

   // receiver stalls
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // compare each accepted code word with the oldest expectation
   always @(posedge clock) begin
      code_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (code_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected code word %h last %b", rsp_code_word, rsp_last);
         end else begin
            e = code_q.pop_front();
            if (rsp_code_word !== e.word || rsp_last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("code word mismatch: expected %h last %b, got %h last %b",
                           e.word, e.last, rsp_code_word, rsp_last);
            end
         end
      end
   end

   stim_row_type directed [] = '{
      '{1, hsq_pkg::CSR_DIM,  64'd1, 0, 0},
      '{1, hsq_pkg::CSR_SEED, 64'd0, 0, 0},
      '{0, 0, 64'h0000, 1, 64'd0},   // all zero vector codes zero
      '{0, 0, 64'h7FFF, 0, 0},
      '{0, 0, 64'h8000, 0, 0},
      '{0, 0, 64'h0001, 0, 0},
      '{0, 0, 64'hFFFF, 0, 0},
      '{1, hsq_pkg::CSR_DIM,  64'd0, 0, 0},   // zero dim acts as one
      '{0, 0, 64'h0000, 1, 64'd0},
      '{0, 0, 64'h3039, 0, 0},
      '{1, hsq_pkg::CSR_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0},
      '{1, hsq_pkg::CSR_DIM,  64'd4, 0, 0},
      '{0, 0, 64'h8000, 0, 0},
      '{0, 0, 64'h7FFF, 0, 0},
      '{0, 0, 64'hFFFF, 0, 0},
      '{0, 0, 64'h0001, 0, 0},
      '{1, hsq_pkg::CSR_DIM,  64'd8, 0, 0},
      '{0, 0, 64'h1234, 0, 0},
      '{0, 0, 64'hABCD, 0, 0},
      '{0, 0, 64'h0F0F, 0, 0},
      '{0, 0, 64'hF0F0, 0, 0},
      '{0, 0, 64'h5555, 0, 0},
      '{1, hsq_pkg::CSR_DIM,  64'd3, 0, 0},   // dim lowered mid-vector: next sample completes it
      '{0, 0, 64'h2AAA, 0, 0},
      '{1, hsq_pkg::CSR_SEED, 64'h0123_4567_89AB_CDEF, 0, 0},
      '{1, hsq_pkg::CSR_DIM,  64'd5, 0, 0},   // pad of eight, upper code bits zero
      '{0, 0, 64'h0000, 0, 0},
      '{0, 0, 64'h0000, 0, 0},
      '{0, 0, 64'h0000, 0, 0},
      '{0, 0, 64'h0000, 0, 0},
      '{0, 0, 64'h0000, 1, 64'd0}
   };

   initial begin
      seed_reg  = '0;
      dim_reg   = 11'd1024;
      vec_count = 0;
      for (int i = 0; i < hsq_pkg::MAX_PAD; i++) vec_store[i] = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (directed[i]) begin
         if (directed[i].is_cfg) begin
            csr_write(directed[i].idx, directed[i].data);
         end else begin
            typed_pending = directed[i].has_exp;
            typed_word    = directed[i].exp_word;
            send_sample(directed[i].data[15:0]);
            typed_pending = 0;
         end
      end

      // random vectors, sender lightly idle and receiver heavily
      req_idle_pct = 23;
      rsp_idle_pct = 60;
      for (int v = 0; v < 6; v++) random_vector(40);
      // long receiver hold-off while requests keep coming, three vectors back to back
      csr_write(hsq_pkg::CSR_DIM, 64'd16);
      hold_cycles = 3000;
      for (int v = 0; v < 3; v++) begin
         for (int i = 0; i < 16; i++) send_sample(rand_sample());
      end
      drain();

      // roles swapped
      req_idle_pct = 60;
      rsp_idle_pct = 23;
      for (int v = 0; v < 5; v++) random_vector(40);
      csr_write(hsq_pkg::CSR_DIM, 64'd128);
      for (int i = 0; i < 128; i++) send_sample(rand_sample());

      // no idling; oversize dim clamps, then a lower dim completes the vector
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      for (int v = 0; v < 2; v++) random_vector(40);
      csr_write(hsq_pkg::CSR_SEED, {$urandom, $urandom});
      csr_write(hsq_pkg::CSR_DIM, 64'd2047);
      for (int i = 0; i < 20; i++) send_sample(rand_sample());
      csr_write(hsq_pkg::CSR_DIM, 64'd16);
      send_sample(rand_sample());

      drain();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== hadamard_sign_quantizer_unit.f =====
hdl/hsq_pkg.sv
hdl/hsq_vec_ram.sv
hdl/hsq_sign_gen.sv
hdl/hsq_pack.sv
hdl/hadamard_sign_quantizer_unit.sv
sim/testbench.sv
